>>> rtl/core/gomg_pkg.sv
// Shared types, constants and helper functions of the glyph outline mask generator.
// No dependencies; imported by every module under rtl/core.
package gomg_pkg;

  // Glyph geometry
  localparam int MAX_GLYPH_WIDTH = 32;
  localparam int ROW_W           = 32;
  localparam int WIDTH_W         = 6;
  localparam int WIDTH_LIM       = (MAX_GLYPH_WIDTH > ROW_W) ? ROW_W : MAX_GLYPH_WIDTH;

  // Stream beat layouts, packed to whole bytes
  localparam int IN_DATA_W  = ((ROW_W + WIDTH_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * ROW_W + 7) / 8) * 8;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [WIDTH_W-1:0] width_t;

  // One result row
  typedef struct packed {
    row_t inner_mask;
    row_t outer_mask;
    logic glyph_end;
  } result_t;

  // Results handed from the row stage to the queue in one cycle
  typedef struct packed {
    logic [1:0] num;     // 0, 1 or 2 results
    result_t    first;
    result_t    second;
  } push_t;

  // Saturate a width field to the supported glyph width
  function automatic width_t clamp_width(width_t w);
    width_t lim;
    lim = width_t'(WIDTH_LIM);
    if (w > lim) begin
      return lim;
    end
    return w;
  endfunction

  // Ones in the columns that lie inside the glyph
  function automatic row_t width_mask(width_t w);
    row_t m;
    if (w >= width_t'(ROW_W)) begin
      m = '1;
    end else begin
      m = ~({ROW_W{1'b1}} << w);
    end
    return m;
  endfunction

  // Inner and outer masks of one row from its two vertical neighbours
  function automatic result_t outline(row_t above, row_t cur, row_t below, width_t w,
                                      logic last);
    row_t    col;
    row_t    near;
    row_t    m;
    result_t r;
    m            = width_mask(w);
    col          = above | cur | below;
    near         = col | (col << 1) | (col >> 1);
    r.inner_mask = cur & m;
    r.outer_mask = near & ~(cur & m) & m;
    r.glyph_end  = last;
    return r;
  endfunction

endpackage

>>> rtl/core/gomg_row_stage.sv
// Input register, row history and outline logic of the glyph outline mask generator.
// Depends on gomg_pkg; feeds gomg_out_fifo with up to two results per row.
module gomg_row_stage import gomg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  row_t  in_row,
  input  width_t in_width,
  input  logic  in_last,
  input  logic  room,       // queue can take two results
  output push_t push
);

  logic   vld_r;
  row_t   row_r;
  width_t width_r;
  logic   last_r;

  row_t   held_row_r,   held_row_nxt;
  row_t   above_row_r,  above_row_nxt;
  width_t held_width_r, held_width_nxt;
  logic   pending_r,    pending_nxt;

  logic   fire;
  logic   take;
  row_t   above_new;
  width_t w_clamped;

  assign fire     = vld_r & room;
  assign in_ready = ~vld_r | room;
  assign take     = in_valid & in_ready;
  assign w_clamped = clamp_width(in_width);

  // Capture a beat, masked to its own width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (fire) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      width_r <= w_clamped;
      row_r   <= in_row & width_mask(w_clamped);
      last_r  <= in_last;
    end
  end

  // Form results and the next row history
  always_comb begin
    above_new      = pending_r ? held_row_r : '0;
    push           = '0;
    held_row_nxt   = held_row_r;
    above_row_nxt  = above_row_r;
    held_width_nxt = held_width_r;
    pending_nxt    = pending_r;
    if (fire) begin
      if (pending_r) begin
        push.first = outline(above_row_r, held_row_r, row_r, held_width_r, 1'b0);
        push.second = outline(above_new, row_r, '0, width_r, 1'b1);
      end else begin
        push.first = outline(above_new, row_r, '0, width_r, 1'b1);
      end
      push.num = {1'b0, pending_r} + {1'b0, last_r};
      if (last_r) begin
        held_row_nxt   = '0;
        above_row_nxt  = '0;
        held_width_nxt = '0;
        pending_nxt    = 1'b0;
      end else begin
        held_row_nxt   = row_r;
        above_row_nxt  = above_new;
        held_width_nxt = width_r;
        pending_nxt    = 1'b1;
      end
    end
  end

  // Hold the two rows of history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_row_r   <= '0;
      above_row_r  <= '0;
      held_width_r <= '0;
      pending_r    <= 1'b0;
    end else begin
      held_row_r   <= held_row_nxt;
      above_row_r  <= above_row_nxt;
      held_width_r <= held_width_nxt;
      pending_r    <= pending_nxt;
    end
  end

endmodule

>>> rtl/core/gomg_out_fifo.sv
// Small result queue of the glyph outline mask generator: takes up to two results a cycle.
// Depends on gomg_pkg; drives the result stream beats.
module gomg_out_fifo import gomg_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t              mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r,  count_nxt;
  logic                  pop;
  logic [FIFO_PTR_W-1:0] wr_ptr_1;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid & out_ready;
  assign out_data  = mem[rd_ptr_r];
  assign room      = (count_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign wr_ptr_1  = FIFO_PTR_W'(wr_ptr_r + 1'b1);

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = FIFO_PTR_W'(wr_ptr_r + push.num);
    rd_ptr_nxt = FIFO_PTR_W'(rd_ptr_r + pop);
    count_nxt  = FIFO_CNT_W'(count_r + FIFO_CNT_W'(push.num) - FIFO_CNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the results in order
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr_r] <= push.first;
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr_1] <= push.second;
    end
  end

endmodule

>>> rtl/core/glyph_outline_mask_generator.sv
// Top level of the glyph outline mask generator: stream ports around the row stage and queue.
// Depends on gomg_pkg, gomg_row_stage and gomg_out_fifo.
//
// Takes one glyph bitmap row per beat and returns, one row behind, the row's ink (inner mask)
// and the clear pixels that touch ink among their eight neighbours (outer mask), both cut to
// the glyph width (widths above 32 saturate). A row beat is accepted every cycle while the
// result queue has room. Each accepted row is registered in the row stage, its results are
// written to the result queue, and the queue hands them out in order. The first row of a multi-row glyph gives no
// result, middle rows give one, and the row marked tlast gives two (or one for a one-row glyph),
// the final one with out_tlast high. The output port moves one result beat per cycle while
// out_tready is high, so a glyph of N rows gives N result beats at the output; a four-entry
// result queue lets the input keep running while results wait.
module glyph_outline_mask_generator import gomg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // row_bits[31:0], row_width[37:32], zero pad
  input  logic                  in_tlast,   // last_row
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // inner_mask[31:0], outer_mask[63:32]
  output logic                  out_tlast   // glyph_end
);

  push_t   push;
  logic    room;
  result_t res;

  // Row history and outline logic
  gomg_row_stage u_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_row   (in_tdata[ROW_W-1:0]),
    .in_width (in_tdata[ROW_W+WIDTH_W-1:ROW_W]),
    .in_last  (in_tlast),
    .room     (room),
    .push     (push)
  );

  // Result queue
  gomg_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res)
  );

  // Pack the result beat
  assign out_tdata = OUT_DATA_W'({res.outer_mask, res.inner_mask});
  assign out_tlast = res.glyph_end;

endmodule

>>> bench/glyph_outline_mask_generator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for glyph_outline_mask_generator: row beats in, inner/outer mask beats out.
// Tracks held rows in a small scoreboard class and checks every result beat in order.
// Depends on gomg_pkg and the glyph_outline_mask_generator RTL only.
module glyph_outline_mask_generator_tb;
  import gomg_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ROWS  = 125;

  // Predicts outline masks from accepted rows and checks result beats against them
  class outline_check;
    row_t    held_row;
    row_t    above_row;
    width_t  held_width;
    bit      row_pending;
    result_t pending_masks[$];
    int      errors;
    int      rows_seen;
    int      glyphs_seen;
    int      results_seen;

    function new();
      held_row     = '0;
      above_row    = '0;
      held_width   = '0;
      row_pending  = 1'b0;
      errors       = 0;
      rows_seen    = 0;
      glyphs_seen  = 0;
      results_seen = 0;
    endfunction

    // Saturate the width field at the row size
    function width_t eff_width(width_t w);
      return (w > width_t'(ROW_W)) ? width_t'(ROW_W) : w;
    endfunction

    // Ones in columns [0, w)
    function row_t inside_cols(width_t w);
      row_t m;
      m = '0;
      for (int c = 0; c < ROW_W; c++) begin
        if (c < w) m[c] = 1'b1;
      end
      return m;
    endfunction

    // Dilate the three rows horizontally and strip the ink of the center row
    function result_t masks_of(row_t above, row_t cur, row_t below, width_t w, bit gend);
      row_t    span;
      row_t    touch;
      row_t    m;
      result_t r;
      m            = inside_cols(w);
      span         = above | cur | below;
      touch        = span | (span << 1) | (span >> 1);
      r.inner_mask = cur & m;
      r.outer_mask = touch & ~(cur & m) & m;
      r.glyph_end  = gend;
      return r;
    endfunction

    function void note_row(row_t bits, width_t w_raw, bit last);
      width_t w;
      row_t   row;
      row_t   new_above;
      w         = eff_width(w_raw);
      row       = bits & inside_cols(w);
      new_above = '0;
      rows_seen++;
      if (row_pending) begin
        pending_masks.push_back(masks_of(above_row, held_row, row, held_width, 1'b0));
        new_above = held_row;
      end
      if (last) begin
        pending_masks.push_back(masks_of(new_above, row, '0, w, 1'b1));
        glyphs_seen++;
        held_row    = '0;
        above_row   = '0;
        held_width  = '0;
        row_pending = 1'b0;
      end else begin
        above_row   = new_above;
        held_row    = row;
        held_width  = w;
        row_pending = 1'b1;
      end
    endfunction

    function void check_result(row_t inner, row_t outer, logic gend);
      result_t exp_r;
      results_seen++;
      if (pending_masks.size() == 0) begin
        $display("%0t: unexpected result beat inner %h outer %h end %b",
                 $time, inner, outer, gend);
        errors++;
        return;
      end
      exp_r = pending_masks.pop_front();
      if (inner !== exp_r.inner_mask) begin
        $display("%0t: inner_mask expected %h actual %h", $time, exp_r.inner_mask, inner);
        errors++;
      end
      if (outer !== exp_r.outer_mask) begin
        $display("%0t: outer_mask expected %h actual %h", $time, exp_r.outer_mask, outer);
        errors++;
      end
      if (gend !== exp_r.glyph_end) begin
        $display("%0t: glyph_end expected %b actual %b", $time, exp_r.glyph_end, gend);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // row_bits[31:0], row_width[37:32], zero pad
  logic                  in_tlast = 1'b0; // last_row
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // inner_mask[31:0], outer_mask[63:32]
  logic                  out_tlast;       // glyph_end

  outline_check sb = new();
  int unsigned  idle_pct  = 0;
  int unsigned  stall_pct = 0;
  int unsigned  rows_sent = 0;
  int           quiet_cycles = 0;

  glyph_outline_mask_generator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Take result beats and stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      sb.check_result(out_tdata[ROW_W-1:0], out_tdata[2*ROW_W-1:ROW_W], out_tlast);
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Abort when no beat moves on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Present one row beat, idling first at random, and hold it until taken
  task automatic send_row(row_t bits, width_t w, bit last);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({w, bits});
    in_tlast  <= last;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_row(bits, w, last);
    rows_sent++;
  endtask

  function automatic row_t random_row();
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3, 4:    return $urandom & $urandom & $urandom;
      5, 6:    return $urandom | $urandom;
      7:       return row_t'(1) << $urandom_range(ROW_W - 1);
      8:       return '0;
      default: return '1;
    endcase
  endfunction

  // One glyph of random height; width mostly legal and fixed, sometimes odd or changing
  task automatic send_glyph();
    int unsigned n_rows;
    int unsigned mode;
    width_t      w;
    n_rows = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 14);
    mode   = $urandom_range(99);
    if (mode < 80)      w = width_t'($urandom_range(1, 32));
    else if (mode < 85) w = '0;
    else if (mode < 95) w = width_t'($urandom_range(33, 63));
    else                w = '0;
    for (int unsigned i = 0; i < n_rows; i++) begin
      if (mode >= 95) w = width_t'($urandom_range(0, 63));
      send_row(random_row(), w, i == n_rows - 1);
    end
  endtask

  initial begin
    int unsigned phase_start;
    int unsigned idle_set[4];
    int unsigned stall_set[4];
    idle_set  = '{0, 85, 0, 31};
    stall_set = '{0, 0, 85, 31};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, single-row glyphs, odd widths, edge ink
    send_row('1, 6'd32, 1'b1);
    send_row(32'h0000_0001, 6'd1, 1'b1);
    send_row('1, 6'd0, 1'b1);
    send_row(32'hA5A5_5A5A, 6'd63, 1'b1);
    send_row('0, 6'd32, 1'b0);
    send_row(32'h0000_8000, 6'd32, 1'b0);
    send_row('0, 6'd32, 1'b1);
    send_row(32'h8000_0001, 6'd32, 1'b0);
    send_row(32'h8000_0001, 6'd32, 1'b1);
    // Ink beyond the width must not leak as pixel or neighbor
    send_row(32'hFFFF_FF00, 6'd8, 1'b0);
    send_row(32'h0000_0100, 6'd8, 1'b0);
    send_row(32'h0000_0080, 6'd8, 1'b1);
    // Width changing inside a glyph
    send_row(32'h0000_000F, 6'd4, 1'b0);
    send_row('0, 6'd16, 1'b0);
    send_row(32'hFFFF_FFFF, 6'd2, 1'b0);
    send_row(32'h0000_0001, 6'd33, 1'b1);
    send_row(32'h0000_0015, 6'd5, 1'b0);
    send_row(32'h0000_000A, 6'd5, 1'b1);
    send_row('0, 6'd32, 1'b1);

    // Random glyphs under each idling mix
    for (int p = 0; p < 4; p++) begin
      idle_pct    = idle_set[p];
      stall_pct   = stall_set[p];
      phase_start = rows_sent;
      while (rows_sent - phase_start < PHASE_ROWS) send_glyph();
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;

    // Drain, then give stray beats a chance to show up
    while (sb.pending_masks.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    foreach (sb.pending_masks[i]) begin
      $display("%0t: missing result expected inner %h outer %h end %b", $time,
               sb.pending_masks[i].inner_mask, sb.pending_masks[i].outer_mask,
               sb.pending_masks[i].glyph_end);
      sb.errors++;
    end

    $display("Sent %0d rows in %0d glyphs, checked %0d result beats,", rows_sent,
             sb.glyphs_seen, sb.results_seen);
    $display("over free-running, sender-idle, receiver-stall and mixed handshake phases.");
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/gomg_pkg.sv
rtl/core/gomg_row_stage.sv
rtl/core/gomg_out_fifo.sv
rtl/core/glyph_outline_mask_generator.sv
bench/glyph_outline_mask_generator_tb.sv
